@@ sv/nndm_pkg.sv @@
// shared constants, codes and control types of the distance matching block
package nndm_pkg;

  localparam int MAX_POINTS     = 64;
  localparam int MAX_REFERENCES = 1024;
  localparam int DISTANCE_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_DIST = 2'd0,
    CMD_LOAD_REF  = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_READ      = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    REG_POINT_COUNT     = 2'd0,
    REG_REFERENCE_COUNT = 2'd1,
    REG_PHI             = 2'd2,
    REG_KEEP_FLOOR      = 2'd3
  } reg_index_t;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_MASK = 1'b1;

  typedef struct packed {
    logic init;
    logic load_near;
    logic set_bit;
    logic mode_next;
    logic inclusive;
  } cell_ctrl_t;

endpackage

@@ sv/nndm_ram.sv @@
// generic single write port memory with registered read
module nndm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/nndm_cell.sv @@
// one matrix row: mask, nearest neighbour and one stage of the search chain
module nndm_cell #(
  parameter int MAX_POINTS     = nndm_pkg::MAX_POINTS,
  parameter int DISTANCE_WIDTH = nndm_pkg::DISTANCE_WIDTH,
  parameter int CELL_INDEX     = 0,
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int NW = $clog2(MAX_POINTS + 1),
  localparam int BW = DISTANCE_WIDTH + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  nndm_pkg::cell_ctrl_t      ctrl,
  input  logic [NW-1:0]             n,
  input  logic [IW-1:0]             row_sel,
  input  logic [IW-1:0]             near_idx,
  input  logic [DISTANCE_WIDTH-1:0] near_val,
  input  logic [BW-1:0]             bound,
  input  logic                      sel_bit,
  input  logic [BW-1:0]             best_in,
  input  logic [IW-1:0]             brow_in,
  input  logic [NW-1:0]             cnt_t_in,
  input  logic [NW-1:0]             cnt_m_in,
  output logic [BW-1:0]             best_out,
  output logic [IW-1:0]             brow_out,
  output logic [NW-1:0]             cnt_t_out,
  output logic [NW-1:0]             cnt_m_out,
  output logic [MAX_POINTS-1:0]     mask
);

  localparam logic [NW-1:0] IDX     = NW'(CELL_INDEX);
  localparam logic [IW-1:0] IDX_ROW = IW'(CELL_INDEX);

  logic [IW-1:0]             nidx;
  logic [DISTANCE_WIDTH-1:0] nval;
  logic                      active;
  logic                      selected;
  logic                      valid;
  logic [BW-1:0]             near_ext;
  logic                      hit_t;
  logic                      cond;
  logic                      take;

  assign active   = IDX < n;
  assign selected = row_sel == IDX_ROW;
  assign valid    = !mask[nidx];
  assign near_ext = {1'b0, nval};
  assign hit_t    = active && (!valid || near_ext <= bound);
  assign cond     = ctrl.inclusive ? (near_ext >= bound) : (near_ext > bound);
  assign take     = ctrl.mode_next && active && valid && cond && (near_ext < best_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      nidx <= '0;
    end else if (ctrl.init) begin
      mask <= active ? (MAX_POINTS'(1) << CELL_INDEX) : '0;
      nidx <= '0;
    end else begin
      if (ctrl.load_near && selected) begin
        nidx <= near_idx;
      end
      if (ctrl.set_bit && selected) begin
        mask[nidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_near && selected) begin
      nval <= near_val;
    end
    best_out  <= take ? near_ext : best_in;
    brow_out  <= take ? IDX_ROW : brow_in;
    cnt_t_out <= cnt_t_in + NW'(hit_t);
    cnt_m_out <= cnt_m_in + NW'(active && sel_bit);
  end

endmodule

@@ sv/nearest_neighbour_distance_matching.sv @@
// top level: config registers, sequencer, distance and reference memories, row chain
// Load and read-mask transactions are taken only while idle; a read answer sits in the
// output register, and a following load or run transaction is taken while it waits,
// while a further read is held until the answer leaves. A run does a first neighbour
// search over all rows through the distance memory port, then a radius search and
// check on the row chain, and per radius step a pass of chain statistics, a reference
// scan through the reference memory port and a decision; each masked entry adds a row
// search through the distance memory port. The number of steps depends on the data.
// No reset clearing pass is needed: a run rebuilds all masks.
module nearest_neighbour_distance_matching #(
  parameter int MAX_POINTS     = nndm_pkg::MAX_POINTS,
  parameter int MAX_REFERENCES = nndm_pkg::MAX_REFERENCES,
  parameter int DISTANCE_WIDTH = nndm_pkg::DISTANCE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [5:0]  row,
  input  logic [5:0]  column,
  input  logic [9:0]  ref_index,
  input  logic [31:0] distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [5:0]  row_out,
  output logic [63:0] row_mask,
  output logic [12:0] masked_total
);

  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int BW  = DISTANCE_WIDTH + 1;
  localparam int DW  = DISTANCE_WIDTH;
  localparam int DAW = $clog2(MAX_POINTS * MAX_POINTS);
  localparam int RAW = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int RCW = $clog2(MAX_REFERENCES + 1);
  localparam int CW  = ((BW > 32) ? BW : 32) + 1;
  localparam int PW  = 17 + NW;
  localparam logic [BW-1:0] INF = {1'b1, {DW{1'b0}}};

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_INIT       = 10'b0000000010,
    S_FIND       = 10'b0000000100,
    S_PASS_NEXT  = 10'b0000001000,
    S_CHECK      = 10'b0000010000,
    S_PASS_STATS = 10'b0000100000,
    S_REFS       = 10'b0001000000,
    S_MULT       = 10'b0010000000,
    S_DECIDE     = 10'b0100000000,
    S_DONE       = 10'b1000000000
  } state_t;

  // configuration registers
  logic [6:0]  point_count;
  logic [10:0] reference_count;
  logic [31:0] phi;
  logic [16:0] keep_floor;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count     <= 7'd64;
      reference_count <= 11'd1024;
      phi             <= 32'hFFFF_FFFF;
      keep_floor      <= 17'd32768;
    end else if (psel && penable && pwrite && pready) begin
      unique case (nndm_pkg::reg_index_t'(paddr[3:2]))
        nndm_pkg::REG_POINT_COUNT:     point_count     <= pwdata[6:0];
        nndm_pkg::REG_REFERENCE_COUNT: reference_count <= pwdata[10:0];
        nndm_pkg::REG_PHI:             phi             <= pwdata;
        nndm_pkg::REG_KEEP_FLOOR:      keep_floor      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (nndm_pkg::reg_index_t'(paddr[3:2]))
      nndm_pkg::REG_POINT_COUNT:     prdata = {25'd0, point_count};
      nndm_pkg::REG_REFERENCE_COUNT: prdata = {21'd0, reference_count};
      nndm_pkg::REG_PHI:             prdata = phi;
      nndm_pkg::REG_KEEP_FLOOR:      prdata = {15'd0, keep_floor};
      default:                       prdata = '0;
    endcase
  end

  // saturated sizes
  logic [NW-1:0]  n_eff;
  logic [RCW-1:0] r_eff;

  always_comb begin
    if (point_count < 7'd2) begin
      n_eff = NW'(2);
    end else if (32'(point_count) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
    if (reference_count == 11'd0) begin
      r_eff = RCW'(1);
    end else if (32'(reference_count) > MAX_REFERENCES) begin
      r_eff = RCW'(MAX_REFERENCES);
    end else begin
      r_eff = RCW'(reference_count);
    end
  end

  state_t state;

  logic [NW-1:0]  j;
  logic           pend;
  logic [IW-1:0]  jd;
  logic [IW-1:0]  fr;
  logic           fr_all;
  logic [BW-1:0]  best;
  logic [IW-1:0]  best_idx;
  logic           found;
  logic [NW-1:0]  pc;
  logic [BW-1:0]  radius;
  logic [IW-1:0]  radius_row;
  logic           inclusive_r;
  logic [NW-1:0]  t_cnt;
  logic [NW-1:0]  m_cnt;
  logic [RCW-1:0] k;
  logic [RCW-1:0] g;
  logic [PW-1:0]  p_train;
  logic [PW-1:0]  p_ref;
  logic [PW-1:0]  p_prop;
  logic [PW-1:0]  p_kept;
  logic [12:0]    mask_count;

  logic           in_acc;
  logic           out_free;
  logic           do_mask;
  logic [NW-1:0]  kept;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) ||
                    (out_valid && out_stall && command == nndm_pkg::CMD_READ);
  assign kept     = n_eff - m_cnt;
  assign do_mask  = (p_train >= p_ref) && (p_kept > p_prop);

  // memories
  logic [DW-1:0] dist_rd;
  logic [DW-1:0] ref_rd;
  logic          dist_we;
  logic          ref_we;

  assign dist_we = in_acc && command == nndm_pkg::CMD_LOAD_DIST &&
                   32'(row) < MAX_POINTS && 32'(column) < MAX_POINTS;
  assign ref_we  = in_acc && command == nndm_pkg::CMD_LOAD_REF &&
                   32'(ref_index) < MAX_REFERENCES;

  nndm_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS * MAX_POINTS)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (DAW'(row * MAX_POINTS + column)),
    .wdata (DW'(distance)),
    .raddr (DAW'(fr * MAX_POINTS + j)),
    .rdata (dist_rd)
  );

  nndm_ram #(.WIDTH(DW), .DEPTH(MAX_REFERENCES)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (RAW'(ref_index)),
    .wdata (DW'(distance)),
    .raddr (RAW'(k)),
    .rdata (ref_rd)
  );

  // row chain
  nndm_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]         row_sel;
  logic [IW-1:0]         mrow;
  logic [MAX_POINTS-1:0] mrow_mask;
  logic [MAX_POINTS-1:0] mask_all [MAX_POINTS];
  logic [BW-1:0]         best_c   [MAX_POINTS+1];
  logic [IW-1:0]         brow_c   [MAX_POINTS+1];
  logic [NW-1:0]         cnt_t_c  [MAX_POINTS+1];
  logic [NW-1:0]         cnt_m_c  [MAX_POINTS+1];

  always_comb begin
    ctrl.init      = state == S_INIT;
    ctrl.load_near = state == S_FIND && j == n_eff && !pend && found;
    ctrl.set_bit   = state == S_DECIDE && do_mask;
    ctrl.mode_next = state == S_PASS_NEXT;
    ctrl.inclusive = inclusive_r;
  end

  assign row_sel = (state == S_DECIDE) ? radius_row : fr;

  always_comb begin
    if (state == S_IDLE) begin
      mrow = IW'(row);
    end else if (state == S_FIND) begin
      mrow = fr;
    end else begin
      mrow = radius_row;
    end
  end

  assign mrow_mask = mask_all[mrow];

  assign best_c[0]  = INF;
  assign brow_c[0]  = '0;
  assign cnt_t_c[0] = '0;
  assign cnt_m_c[0] = '0;

  for (genvar c = 0; c < MAX_POINTS; c++) begin : g_cell
    nndm_cell #(
      .MAX_POINTS     (MAX_POINTS),
      .DISTANCE_WIDTH (DISTANCE_WIDTH),
      .CELL_INDEX     (c)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .n         (n_eff),
      .row_sel   (row_sel),
      .near_idx  (best_idx),
      .near_val  (best[DW-1:0]),
      .bound     (radius),
      .sel_bit   (mrow_mask[c]),
      .best_in   (best_c[c]),
      .brow_in   (brow_c[c]),
      .cnt_t_in  (cnt_t_c[c]),
      .cnt_m_in  (cnt_m_c[c]),
      .best_out  (best_c[c+1]),
      .brow_out  (brow_c[c+1]),
      .cnt_t_out (cnt_t_c[c+1]),
      .cnt_m_out (cnt_m_c[c+1]),
      .mask      (mask_all[c])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend        <= 1'b0;
      mask_count  <= '0;
      radius      <= INF;
      radius_row  <= '0;
      inclusive_r <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && command == nndm_pkg::CMD_RUN) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          mask_count <= '0;
          radius_row <= '0;
          fr         <= '0;
          fr_all     <= 1'b1;
          j          <= '0;
          pend       <= 1'b0;
          best       <= INF;
          found      <= 1'b0;
          state      <= S_FIND;
        end
        S_FIND: begin
          if (j < n_eff) begin
            jd   <= IW'(j);
            j    <= j + NW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && !mrow_mask[jd] && {1'b0, dist_rd} < best) begin
            best     <= {1'b0, dist_rd};
            best_idx <= jd;
            found    <= 1'b1;
          end
          if (j == n_eff && !pend) begin
            if (fr_all && fr != IW'(n_eff - NW'(1))) begin
              fr    <= fr + IW'(1);
              j     <= '0;
              best  <= INF;
              found <= 1'b0;
            end else begin
              if (fr_all) begin
                radius <= '0;
              end
              inclusive_r <= 1'b1;
              pc          <= '0;
              state       <= S_PASS_NEXT;
            end
          end
        end
        S_PASS_NEXT: begin
          pc <= pc + NW'(1);
          if (pc == NW'(MAX_POINTS)) begin
            radius <= best_c[MAX_POINTS];
            if (best_c[MAX_POINTS] != INF) begin
              radius_row <= brow_c[MAX_POINTS];
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          pc <= '0;
          if (CW'(radius) <= CW'(phi)) begin
            state <= S_PASS_STATS;
          end else begin
            state <= S_DONE;
          end
        end
        S_PASS_STATS: begin
          pc <= pc + NW'(1);
          if (pc == NW'(MAX_POINTS)) begin
            t_cnt <= cnt_t_c[MAX_POINTS];
            m_cnt <= cnt_m_c[MAX_POINTS];
            k     <= '0;
            g     <= '0;
            pend  <= 1'b0;
            state <= S_REFS;
          end
        end
        S_REFS: begin
          if (k < r_eff) begin
            k    <= k + RCW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && {1'b0, ref_rd} <= radius) begin
            g <= g + RCW'(1);
          end
          if (k == r_eff && !pend) begin
            state <= S_MULT;
          end
        end
        S_MULT: begin
          p_train <= PW'(t_cnt - NW'(1)) * PW'(r_eff);
          p_ref   <= PW'(g) * PW'(n_eff);
          p_prop  <= PW'(keep_floor) * PW'(n_eff);
          p_kept  <= PW'({kept, 16'd0});
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (do_mask) begin
            mask_count <= mask_count + 13'd1;
            fr         <= radius_row;
            fr_all     <= 1'b0;
            j          <= '0;
            pend       <= 1'b0;
            best       <= INF;
            found      <= 1'b0;
            state      <= S_FIND;
          end else if (t_cnt == n_eff) begin
            state <= S_DONE;
          end else begin
            inclusive_r <= 1'b0;
            pc          <= '0;
            state       <= S_PASS_NEXT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && command == nndm_pkg::CMD_READ) begin
      out_valid <= 1'b1;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && command == nndm_pkg::CMD_READ) begin
      kind         <= nndm_pkg::KIND_MASK;
      row_out      <= row;
      row_mask     <= (32'(row) < MAX_POINTS) ? 64'(mrow_mask) : '0;
      masked_total <= mask_count;
    end else if (state == S_DONE && out_free) begin
      kind         <= nndm_pkg::KIND_RUN;
      row_out      <= '0;
      row_mask     <= '0;
      masked_total <= mask_count;
    end
  end

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == S_IDLE)
    else $error("transaction taken outside idle");

  a_count_source: assert property (@(posedge clk) disable iff (rst)
    mask_count != $past(mask_count) |->
      ($past(state) == S_DECIDE || $past(state) == S_INIT))
    else $error("mask count changed outside decision");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || !out_stall)) |=>
      (out_valid && kind == nndm_pkg::KIND_RUN))
    else $error("run result not presented");

  a_radius_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS_NEXT && pc == NW'(MAX_POINTS) && best_c[MAX_POINTS] != INF) |->
      (inclusive_r ? (best_c[MAX_POINTS] >= radius) : (best_c[MAX_POINTS] > radius)))
    else $error("new radius below bound");

endmodule
